@@ hdl/wwd_pkg.sv @@
// ----------------------------------------------------------------------------
// wwd_pkg: shared types and codes of the weight word decoder
// Element type codes, status codes, register indexes and the record that
// the byte assembler hands to the output stage.
// ----------------------------------------------------------------------------
package wwd_pkg;

   // Field widths
   localparam int BYTE_W   = 8;
   localparam int WORD_W   = 32;
   localparam int GATHER_W = 24;
   localparam int POS_W    = 2;
   localparam int ETYPE_W  = 2;
   localparam int STATUS_W = 2;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 2;

   typedef logic [ETYPE_W-1:0]  etype_type;
   typedef logic [STATUS_W-1:0] status_type;

   // Input encodings held in the element_type register
   localparam etype_type ET_SINGLE   = 2'd0;
   localparam etype_type ET_HALF     = 2'd1;
   localparam etype_type ET_BF16     = 2'd2;
   localparam etype_type ET_RESERVED = 2'd3;

   // Result status codes
   localparam status_type ST_OK        = 2'd0;
   localparam status_type ST_NONFINITE = 2'd1;
   localparam status_type ST_MISMATCH  = 2'd2;
   localparam status_type ST_TRUNCATED = 2'd3;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ELEMENT_TYPE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEAD_CHECK   = 1'd1;

   // What the assembler decided for the byte of the current transaction
   typedef struct packed {
      logic emit;        // a result is produced by this byte
      logic truncated;   // final byte arrived before the element was complete
      logic mismatch;    // some compared byte of the element differed
      logic last;        // this byte closes the tensor
   } asm_res_type;

endpackage

@@ hdl/wwd_convert.sv @@
// ----------------------------------------------------------------------------
// wwd_convert: element to single-precision conversion
// Maps the gathered little-endian word to single-precision bits according to
// the element type and flags non-finite results.
// ----------------------------------------------------------------------------
module wwd_convert (
   input  wwd_pkg::etype_type           element_type,
   input  logic [wwd_pkg::WORD_W-1:0]   word,
   output logic [wwd_pkg::WORD_W-1:0]   value_bits,
   output logic                         nonfinite
);
   import wwd_pkg::*;

   // Exact widening of IEEE half; subnormals are normalized.
   function automatic logic [WORD_W-1:0] widen_half(input logic [15:0] h);
      logic        sign;
      logic [4:0]  ex;
      logic [9:0]  man;
      logic [3:0]  lead;
      logic [3:0]  shift;
      logic [10:0] norm;
      logic [7:0]  e;
      logic [WORD_W-1:0] r;
      sign = h[15];
      ex   = h[14:10];
      man  = h[9:0];
      lead = 4'd0;
      // Position of the leading one of the mantissa.
      for (int i = 0; i < 10; i++) begin
         if (man[i]) begin
            lead = 4'(i);
         end
      end
      shift = 4'd10 - lead;
      norm  = {1'b0, man} << shift;
      e     = 8'd103 + {4'd0, lead};
      if (ex == 5'd0) begin
         if (man == 10'd0) begin
            r = {sign, 31'd0};
         end else begin
            r = {sign, e, norm[9:0], 13'd0};
         end
      end else if (ex == 5'h1F) begin
         r = {sign, 8'hFF, man, 13'd0};
      end else begin
         r = {sign, 8'({3'd0, ex} + 8'd112), man, 13'd0};
      end
      return r;
   endfunction

   // Select the decoding by element type; the unused code decodes as bfloat16.
   always_comb begin
      unique case (element_type) inside
         ET_SINGLE: value_bits = word;
         ET_HALF:   value_bits = widen_half(word[15:0]);
         ET_BF16, ET_RESERVED: value_bits = {word[15:0], 16'd0};
         default:   value_bits = {word[15:0], 16'd0};
      endcase
   end

   assign nonfinite = (value_bits[30:23] == 8'hFF);

endmodule

@@ hdl/wwd_assembler.sv @@
// ----------------------------------------------------------------------------
// wwd_assembler: byte gathering and element state
// Collects payload bytes into an element, tracks head-stream mismatches,
// decides when a result is due and holds off results after an error.
// ----------------------------------------------------------------------------
module wwd_assembler (
   input  logic                          clock,
   input  logic                          reset,
   input  wwd_pkg::etype_type            element_type,
   input  logic                          head_check,
   input  logic                          accept,
   input  logic [wwd_pkg::BYTE_W-1:0]    payload_byte,
   input  logic [wwd_pkg::BYTE_W-1:0]    head_byte,
   input  logic                          final_byte,
   input  logic                          nonfinite,
   output logic [wwd_pkg::WORD_W-1:0]    word,
   output wwd_pkg::asm_res_type          res,
   output logic                          hold
);
   import wwd_pkg::*;

   logic [GATHER_W-1:0] gather_ff, gather_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic                mism_ff, mism_in;
   logic                hold_ff, hold_in;

   logic                mism;
   logic                partial;
   logic [POS_W-1:0]    last_pos;

   // Merge the new byte into the gathered word at its position.
   assign mism     = mism_ff | (head_check & (payload_byte != head_byte));
   assign word     = {8'd0, gather_ff} | ({24'd0, payload_byte} << {pos_ff, 3'd0});
   assign last_pos = (element_type == ET_SINGLE) ? 2'd3 : 2'd1;
   assign partial  = (pos_ff < last_pos);

   // Result decision for this byte.
   always_comb begin
      res.emit      = accept & ~hold_ff & (~partial | final_byte);
      res.truncated = partial;
      res.mismatch  = mism;
      res.last      = final_byte;
   end

   // Next state of the element.
   always_comb begin
      gather_in = gather_ff;
      pos_in    = pos_ff;
      mism_in   = mism_ff;
      hold_in   = hold_ff;
      if (accept) begin
         if (hold_ff || final_byte || !partial) begin
            gather_in = '0;
            pos_in    = '0;
            mism_in   = 1'b0;
         end else begin
            gather_in = word[GATHER_W-1:0];
            pos_in    = pos_ff + 2'd1;
            mism_in   = mism;
         end
         if (final_byte) begin
            hold_in = 1'b0;
         end else if (!hold_ff && !partial && (mism || nonfinite)) begin
            hold_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gather_ff <= '0;
         pos_ff    <= '0;
         mism_ff   <= 1'b0;
         hold_ff   <= 1'b0;
      end else begin
         gather_ff <= gather_in;
         pos_ff    <= pos_in;
         mism_ff   <= mism_in;
         hold_ff   <= hold_in;
      end
   end

   assign hold = hold_ff;

endmodule

@@ hdl/weight_word_decoder.sv @@
// ----------------------------------------------------------------------------
// weight_word_decoder: tensor weight byte stream to single-precision words
// Gathers little-endian bytes into single, half or bfloat16 elements and
// returns each as single-precision bits with a status code.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Transaction contents
//  req_     in         tdata[7:0] payload_byte, tdata[15:8] head_byte,
//                      tlast final_byte
//  rsp_     out        tdata[31:0] value_bits, tdata[33:32] status,
//                      tlast end_of_tensor
//  csr_     in         write enable, register index, write data
//
//  One byte is taken every cycle unless a result waits untaken. The result of
//  the byte that completes an element is in the output register in the next
//  cycle. The output register is the only result storage: while it holds a
//  result that is not taken, req_tready is low. Reset is synchronous and
//  clears the element state, the error hold and both configuration registers.
//
module weight_word_decoder (
   input  logic                              clock,
   input  logic                              reset,
   // Input stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [15:0]                       req_tdata,  // payload_byte, head_byte
   input  logic                              req_tlast,
   // Result stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [39:0]                       rsp_tdata,  // value_bits, status, zero pad
   output logic                              rsp_tlast,
   // Configuration writes
   input  logic                              csr_wen,
   input  logic [wwd_pkg::CSR_IDX_W-1:0]     csr_addr,
   input  logic [wwd_pkg::CSR_DAT_W-1:0]     csr_wdata
);
   import wwd_pkg::*;

   etype_type      etype_ff;
   logic           check_ff;

   logic           accept;
   logic [WORD_W-1:0] word;
   logic [WORD_W-1:0] conv_value;
   logic           nonfinite;
   asm_res_type    res;
   logic           hold;

   status_type     status;
   logic [WORD_W-1:0] value;

   logic           rsp_valid_ff;
   logic [WORD_W-1:0] rsp_value_ff;
   status_type     rsp_status_ff;
   logic           rsp_last_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         etype_ff <= ET_SINGLE;
         check_ff <= 1'b0;
      end else if (csr_wen) begin
         case (csr_addr)
            CSR_ELEMENT_TYPE: etype_ff <= csr_wdata;
            CSR_HEAD_CHECK:   check_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // A transaction is taken whenever the output register can accept a result.
   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign accept     = req_tvalid & req_tready;

   wwd_assembler u_assembler (
      .clock        (clock),
      .reset        (reset),
      .element_type (etype_ff),
      .head_check   (check_ff),
      .accept       (accept),
      .payload_byte (req_tdata[7:0]),
      .head_byte    (req_tdata[15:8]),
      .final_byte   (req_tlast),
      .nonfinite    (nonfinite),
      .word         (word),
      .res          (res),
      .hold         (hold)
   );

   wwd_convert u_convert (
      .element_type (etype_ff),
      .word         (word),
      .value_bits   (conv_value),
      .nonfinite    (nonfinite)
   );

   // Status priority: truncation, then head mismatch, then non-finite.
   always_comb begin
      if (res.truncated) begin
         status = ST_TRUNCATED;
         value  = '0;
      end else begin
         value = conv_value;
         if (res.mismatch) begin
            status = ST_MISMATCH;
         end else if (nonfinite) begin
            status = ST_NONFINITE;
         end else begin
            status = ST_OK;
         end
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && res.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && res.emit) begin
         rsp_value_ff  <= value;
         rsp_status_ff <= status;
         rsp_last_ff   <= res.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_status_ff, rsp_value_ff};
   assign rsp_tlast  = rsp_last_ff;

   // A truncated element always closes the tensor and carries a zero value.
   a_trunc_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == ST_TRUNCATED)
      |-> (rsp_value_ff == '0) && rsp_last_ff)
      else $error("truncated result with nonzero value or without end of tensor");

   // While an error is held no result may be produced.
   a_hold_silent: assert property (@(posedge clock) disable iff (reset)
      hold |-> !res.emit)
      else $error("result produced during error hold");

   // The final byte of a tensor releases the error hold.
   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |=> !hold)
      else $error("error hold survived the final byte");

   // An error on a byte that is not final starts the hold.
   a_error_holds: assert property (@(posedge clock) disable iff (reset)
      accept && res.emit && !res.last && (status != ST_OK) |=> hold)
      else $error("error result did not start the hold");

endmodule
